// File: rtl/fac_pkg.sv
// Package: shared constants, register indexes and types for the framed checksum unit
`timescale 1ns / 1ps
package fac_pkg;

  // Message framing
  localparam int CMD_BYTES   = 6;
  localparam int LINE_BYTES  = 9;
  localparam int TIMER_LINES = 4;
  localparam int ASTRO_LINES = 12;

  // State widths
  localparam int COL_W  = 4;
  localparam int LINE_W = 5;
  localparam int SUM_W  = 8;

  // Check column of each segment kind
  localparam logic [COL_W-1:0] CMD_CHECK_COL  = COL_W'(CMD_BYTES - 1);
  localparam logic [COL_W-1:0] LINE_CHECK_COL = COL_W'(LINE_BYTES - 1);

  // Segment totals per message type, one bit wider than the line count
  localparam logic [LINE_W:0] SEGS_CMD   = (LINE_W+1)'(1);
  localparam logic [LINE_W:0] SEGS_CLOCK = (LINE_W+1)'(2);
  localparam logic [LINE_W:0] SEGS_FULL  = (LINE_W+1)'(2 + TIMER_LINES + ASTRO_LINES);

  // Message type codes
  localparam logic [1:0] MSG_CMD_ONLY  = 2'd0;
  localparam logic [1:0] MSG_CMD_CLOCK = 2'd1;
  localparam logic [1:0] MSG_FULL      = 2'd2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_TYPE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CREATE_MODE  = CFG_IDX_W'(1);

  // Position of the current byte within the message
  typedef struct packed {
    logic check;
    logic last;
  } frame_t;

  // One result item
  typedef struct packed {
    logic [SUM_W-1:0] out_byte;
    logic             check_position;
    logic             mismatch;
    logic             message_last;
    logic             message_ok;
  } result_t;

endpackage

// File: rtl/fac_frame.sv
// Frame tracker: column and line counters that mark checksum and final bytes
`timescale 1ns / 1ps
module fac_frame (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic [1:0]            message_type,
  output fac_pkg::frame_t       frame
);

  logic [fac_pkg::COL_W-1:0]  column_r, column_nxt;
  logic [fac_pkg::LINE_W-1:0] line_r, line_nxt;
  logic [fac_pkg::COL_W-1:0]  check_col;
  logic [fac_pkg::LINE_W:0]   seg_total;
  logic [fac_pkg::LINE_W:0]   line_plus;

  // Pick segment length from the line and segment total from the message type
  always_comb begin
    check_col = (line_r == '0) ? fac_pkg::CMD_CHECK_COL : fac_pkg::LINE_CHECK_COL;
    unique case (message_type)
      fac_pkg::MSG_CMD_ONLY:  seg_total = fac_pkg::SEGS_CMD;
      fac_pkg::MSG_CMD_CLOCK: seg_total = fac_pkg::SEGS_CLOCK;
      default:                seg_total = fac_pkg::SEGS_FULL;
    endcase
    line_plus   = {1'b0, line_r} + (fac_pkg::LINE_W+1)'(1);
    frame.check = (column_r >= check_col);
    frame.last  = frame.check && (line_plus >= seg_total);
  end

  // Advance the counters; clear at message end, step line at each checksum
  always_comb begin
    column_nxt = column_r;
    line_nxt   = line_r;
    if (advance) begin
      if (frame.last) begin
        column_nxt = '0;
        line_nxt   = '0;
      end else if (frame.check) begin
        column_nxt = '0;
        line_nxt   = line_plus[fac_pkg::LINE_W-1:0];
      end else begin
        column_nxt = column_r + fac_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      line_r   <= '0;
    end else begin
      column_r <= column_nxt;
      line_r   <= line_nxt;
    end
  end

endmodule

// File: rtl/fac_sum.sv
// Running sum: checksum compare or insert, mismatch tracking, result assembly
`timescale 1ns / 1ps
module fac_sum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic                       create_mode,
  input  logic [fac_pkg::SUM_W-1:0]  data_byte,
  input  fac_pkg::frame_t            frame,
  output fac_pkg::result_t           result
);

  logic [fac_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic                      failed_r, failed_nxt;
  logic [fac_pkg::SUM_W-1:0] obyte;
  logic                      mism;

  // Replace or compare at checksum positions
  always_comb begin
    obyte = data_byte;
    mism  = 1'b0;
    if (frame.check) begin
      if (create_mode) begin
        obyte = sum_r;
      end else begin
        mism = (data_byte != sum_r);
      end
    end
    result.out_byte       = obyte;
    result.check_position = frame.check;
    result.mismatch       = mism;
    result.message_last   = frame.last;
    result.message_ok     = frame.last && !(failed_r || mism);
  end

  // Accumulate, clear at message end
  always_comb begin
    sum_nxt    = sum_r;
    failed_nxt = failed_r;
    if (advance) begin
      if (frame.last) begin
        sum_nxt    = '0;
        failed_nxt = 1'b0;
      end else begin
        sum_nxt    = sum_r + obyte;
        failed_nxt = failed_r || mism;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      failed_r <= 1'b0;
    end else begin
      sum_r    <= sum_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// File: rtl/framed_additive_checksum_unit.sv
// Top level: config registers, input and result registers around the checksum logic
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   in_     | in        | in_valid/in_stall  | in_data_byte[7:0]
//   out_    | out       | out_valid/out_stall| out_byte, check_position, mismatch,
//           |           |                    | message_last, message_ok
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index[1:0], cfg_data[1:0]
//
// One item per cycle while out_stall is low; an accepted item passes through the
// input register, then the result register, with a single 8-bit add and compare
// between them.
// Reset clears counters, running sum and valid flags; message_type resets to full
// message, create_mode to verify. cfg_ready is always high.
// A stalled result holds in the result register; the input register keeps taking
// items until it is full and the result register cannot drain.
`timescale 1ns / 1ps
module framed_additive_checksum_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_byte,
  output logic                             out_check_position,
  output logic                             out_mismatch,
  output logic                             out_message_last,
  output logic                             out_message_ok,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fac_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [1:0]               msg_type_r, msg_type_nxt;
  logic                     create_r, create_nxt;
  logic                     in_valid_r, in_valid_nxt;
  logic [7:0]               in_byte_r, in_byte_nxt;
  logic                     out_valid_r, out_valid_nxt;
  fac_pkg::result_t         res_r, res_nxt;
  fac_pkg::frame_t          frame;
  fac_pkg::result_t         result;
  logic                     out_free;
  logic                     advance;
  logic                     in_take;

  assign cfg_ready = 1'b1;

  // Decode configuration writes; ignore indexes beyond the list
  always_comb begin
    msg_type_nxt = msg_type_r;
    create_nxt   = create_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fac_pkg::REG_MESSAGE_TYPE: msg_type_nxt = cfg_data[1:0];
        fac_pkg::REG_CREATE_MODE:  create_nxt   = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake between the two register stages
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Input register: load on accept, drop when passed on
  always_comb begin
    in_byte_nxt  = in_take ? in_data_byte : in_byte_r;
    in_valid_nxt = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_r);
  end

  // Result register: refill whenever it is free
  always_comb begin
    out_valid_nxt = out_free ? in_valid_r : out_valid_r;
    res_nxt       = advance ? result : res_r;
  end

  fac_frame u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .message_type (msg_type_r),
    .frame        (frame)
  );

  fac_sum u_sum (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .create_mode (create_r),
    .data_byte   (in_byte_r),
    .frame       (frame),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_type_r  <= fac_pkg::MSG_FULL;
      create_r    <= 1'b0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      msg_type_r  <= msg_type_nxt;
      create_r    <= create_nxt;
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    in_byte_r <= in_byte_nxt;
    res_r     <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = res_r.out_byte;
  assign out_check_position = res_r.check_position;
  assign out_mismatch       = res_r.mismatch;
  assign out_message_last   = res_r.message_last;
  assign out_message_ok     = res_r.message_ok;

endmodule

// File: rtl/fac_checker.sv
// Checker: port-level properties of the framed checksum unit, bound to the top level
`timescale 1ns / 1ps
module fac_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_check_position,
  input  logic       out_mismatch,
  input  logic       out_message_last,
  input  logic       out_message_ok
);

  // Only a checksum byte can carry a mismatch
  a_mismatch_at_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mismatch |-> out_check_position)
    else $error("mismatch flagged on a data byte");

  // A message ends on a checksum byte
  a_last_at_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_last |-> out_check_position)
    else $error("message end on a data byte");

  // Message status only at the end, and never together with a mismatch
  a_ok_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_ok |-> out_message_last && !out_mismatch)
    else $error("message_ok outside message end or with mismatch");

  // A stalled item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(out_message_last))
    else $error("stalled result item changed");

endmodule

bind framed_additive_checksum_unit fac_checker u_fac_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_byte           (out_byte),
  .out_check_position (out_check_position),
  .out_mismatch       (out_mismatch),
  .out_message_last   (out_message_last),
  .out_message_ok     (out_message_ok)
);
